// ----- rtl/core/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants of the program stream PES demultiplexer
// Parser states, stream id codes, the timestamp field helper and the default position width.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int unsigned PositionBitsDefault = 40;
	localparam logic [15:0] MaxPacketSizeReset = 16'hFFFF;

	typedef enum logic [4:0] {
		S_HUNT, S_ID, S_SYS_HI, S_SYS_LO, S_SKIP_HUNT, S_LEN_HI, S_LEN_LO,
		S_P2_SUB, S_STUFF, S_M1_STD, S_M1_C, S_M1_TS, S_M1_DTS_SKIP,
		S_M2_FLAGS, S_M2_HLEN, S_M2_TS, S_M2_HSKIP, S_P1_SUB, S_P1_SKIP,
		S_PAYLOAD
	} parse_state_t;

	localparam logic [7:0] IdPack    = 8'hBA;
	localparam logic [7:0] IdSystem  = 8'hBB;
	localparam logic [7:0] IdPrivate1 = 8'hBD;
	localparam logic [7:0] IdPadding = 8'hBE;
	localparam logic [7:0] IdPrivate2 = 8'hBF;

	// timestamp byte k of the 5-byte marker layout, placed in 33 bits
	function automatic logic [32:0] ts_part(input logic [3:0] k, input logic [7:0] b);
		logic [32:0] r;
		r = '0;
		unique case (k)
			4'd0: r[32:30] = b[3:1];
			4'd1: r[29:22] = b;
			4'd2: r[21:15] = b[7:1];
			4'd3: r[14:7]  = b;
			default: r[6:0] = b[7:1];
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/psd_parser.sv -----
// ----------------------------------------------------------------------------
// psd_parser: byte-wide PES parse state machine
// Consumes one registered stream byte per cycle while step is high and flags at most one result for it.
// ----------------------------------------------------------------------------
module psd_parser #(
	parameter int unsigned POSITION_BITS = psd_pkg::PositionBitsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               b,
	input  logic [15:0]              max_size,
	output logic                     emit,
	output logic [7:0]               o_id,
	output logic [7:0]               o_byte,
	output logic                     o_first,
	output logic                     o_last,
	output logic [15:0]              o_len,
	output logic [32:0]              o_pts,
	output logic                     o_pts_v,
	output logic [32:0]              o_dts,
	output logic                     o_dts_v,
	output logic [POSITION_BITS-1:0] o_off,
	output logic                     o_empty
);
	psd_pkg::parse_state_t st_q, st_d;
	logic [23:0] win_q, win_d;
	logic [7:0]  id_q, id_d, sub_q, sub_d, hrem_q, hrem_d;
	logic signed [16:0] rem_q, rem_d;
	logic [15:0] skip_q, skip_d;
	logic [32:0] pts_q, pts_d, dts_q, dts_d;
	logic [1:0]  tsf_q, tsf_d;
	logic [POSITION_BITS-1:0] pos_q, start_q, start_d;

	// saturating subtract at -65536
	function automatic logic signed [16:0] rsub(input logic signed [16:0] r,
		input logic [7:0] k);
		logic signed [17:0] t;
		t = 18'(r) - 18'(signed'({1'b0, k}));
		if (t < -18'sd65536) t = -18'sd65536;
		return t[16:0];
	endfunction

	always_comb begin
		logic [23:0] w;
		logic [7:0]  s;
		logic [2:0]  extra;
		logic [3:0]  k;
		logic        do_fin, do_ahdr, do_ats, do_m1;
		logic [15:0] skm;
		st_d = st_q; win_d = win_q; id_d = id_q; sub_d = sub_q; hrem_d = hrem_q;
		rem_d = rem_q; skip_d = skip_q; pts_d = pts_q; dts_d = dts_q;
		tsf_d = tsf_q; start_d = start_q;
		emit = 1'b0; o_byte = '0; o_first = 1'b0; o_last = 1'b0; o_len = '0;
		o_empty = 1'b0;
		w = {win_q[15:0], b};
		s = b; extra = '0; k = '0;
		do_fin = 1'b0; do_ahdr = 1'b0; do_ats = 1'b0; do_m1 = 1'b0;
		skm = skip_q - 16'd1;
		unique case (st_q)
			psd_pkg::S_HUNT: begin
				win_d = w;
				if (w == 24'd1) begin
					start_d = pos_q - POSITION_BITS'(2);
					win_d = '1;
					st_d = psd_pkg::S_ID;
				end
			end
			psd_pkg::S_ID: begin
				win_d = w; id_d = b;
				if (b == psd_pkg::IdPack) begin
					skip_d = 16'd8; st_d = psd_pkg::S_SKIP_HUNT;
				end else if (b == psd_pkg::IdPadding || b == psd_pkg::IdSystem) begin
					st_d = psd_pkg::S_SYS_HI;
				end else if ((b >= 8'hC0 && b < 8'hC9) || (b >= 8'hE0 && b < 8'hE9) ||
					(b >= 8'h20 && b < 8'h29) || b == psd_pkg::IdPrivate1 ||
					b == psd_pkg::IdPrivate2) begin
					sub_d = 8'hFF; tsf_d = '0; pts_d = '0; dts_d = '0; hrem_d = '0;
					st_d = psd_pkg::S_LEN_HI;
				end else begin
					st_d = psd_pkg::S_HUNT;
				end
			end
			psd_pkg::S_SYS_HI: begin
				skip_d = {b, 8'h00}; st_d = psd_pkg::S_SYS_LO;
			end
			psd_pkg::S_SYS_LO: begin
				skip_d = {skip_q[15:8], b};
				if ({skip_q[15:8], b} == 16'd0) begin
					st_d = psd_pkg::S_HUNT; win_d = '1;
				end else st_d = psd_pkg::S_SKIP_HUNT;
			end
			psd_pkg::S_SKIP_HUNT: begin
				skip_d = skm;
				if (skm == 16'd0) begin
					st_d = psd_pkg::S_HUNT; win_d = '1;
				end
			end
			psd_pkg::S_LEN_HI: begin
				rem_d = signed'({1'b0, b, 8'h00}); st_d = psd_pkg::S_LEN_LO;
			end
			psd_pkg::S_LEN_LO: begin
				rem_d = signed'({1'b0, rem_q[15:8], b});
				st_d = (id_q == psd_pkg::IdPrivate2) ? psd_pkg::S_P2_SUB : psd_pkg::S_STUFF;
			end
			psd_pkg::S_P2_SUB: begin
				sub_d = b + 8'h60; rem_d = rsub(rem_q, 8'd1); do_fin = 1'b1;
			end
			psd_pkg::S_STUFF: begin
				if (b == 8'hFF) rem_d = rsub(rem_q, 8'd1);
				else if (b[7:6] == 2'b10) st_d = psd_pkg::S_M2_FLAGS;
				else if (b[7:6] == 2'b01) begin
					rem_d = rsub(rem_q, 8'd2); st_d = psd_pkg::S_M1_STD;
				end else do_m1 = 1'b1;
			end
			psd_pkg::S_M1_STD: st_d = psd_pkg::S_M1_C;
			psd_pkg::S_M1_C: do_m1 = 1'b1;
			psd_pkg::S_M1_TS: begin
				k = 4'(5 - skip_q[2:0]);
				pts_d = pts_q | psd_pkg::ts_part(k, b);
				skip_d = skm;
				if (skm == 16'd0) begin
					if (hrem_q != 8'd0) begin
						skip_d = {8'h00, hrem_q}; st_d = psd_pkg::S_M1_DTS_SKIP;
					end else begin
						rem_d = rsub(rem_q, 8'd1); do_fin = 1'b1;
					end
				end
			end
			psd_pkg::S_M1_DTS_SKIP: begin
				skip_d = skm;
				if (skm == 16'd0) begin
					rem_d = rsub(rem_q, 8'd1); do_fin = 1'b1;
				end
			end
			psd_pkg::S_M2_FLAGS: begin
				skip_d = {14'd0, b[7:6]}; st_d = psd_pkg::S_M2_HLEN;
			end
			psd_pkg::S_M2_HLEN: begin
				rem_d = rsub(rem_q, 8'd3);
				if (skip_q == 16'd1) begin
					st_d = psd_pkg::S_HUNT; win_d = '1;
				end else if (skip_q == 16'd2 && b >= 8'd5) begin
					tsf_d = 2'd1; hrem_d = b - 8'd5;
					rem_d = rsub(rsub(rem_q, 8'd3), 8'd5);
					skip_d = 16'd5; st_d = psd_pkg::S_M2_TS;
				end else if (skip_q == 16'd3 && b >= 8'd10) begin
					tsf_d = 2'd3; hrem_d = b - 8'd10;
					rem_d = rsub(rsub(rem_q, 8'd3), 8'd10);
					skip_d = 16'd10; st_d = psd_pkg::S_M2_TS;
				end else begin
					hrem_d = b; do_ats = 1'b1;
				end
			end
			psd_pkg::S_M2_TS: begin
				k = ((tsf_q == 2'd3) ? 4'd10 : 4'd5) - skip_q[3:0];
				if (k < 4'd5) pts_d = pts_q | psd_pkg::ts_part(k, b);
				else dts_d = dts_q | psd_pkg::ts_part(k - 4'd5, b);
				skip_d = skm;
				if (skm == 16'd0 || skm > 16'd10) do_ats = 1'b1;
			end
			psd_pkg::S_M2_HSKIP: begin
				skip_d = skm;
				if (skm == 16'd0) do_ahdr = 1'b1;
			end
			psd_pkg::S_P1_SUB: begin
				if (b >= 8'h88 && b <= 8'h8B) s = b - 8'h48;
				else if (b >= 8'h80 && b <= 8'h87) s = b - 8'h80;
				else if (b >= 8'hA0 && b <= 8'hA7) extra = 3'd3;
				else if (!(b >= 8'h20 && b <= 8'h27)) s = 8'hFF;
				if (s > 8'h26 || s < 8'h20) extra = extra + 3'd3;
				sub_d = s;
				rem_d = rsub(rem_q, 8'(extra) + 8'd1);
				if (extra != 3'd0) begin
					skip_d = 16'(extra); st_d = psd_pkg::S_P1_SKIP;
				end else do_fin = 1'b1;
			end
			psd_pkg::S_P1_SKIP: begin
				skip_d = skm;
				if (skm == 16'd0) do_fin = 1'b1;
			end
			psd_pkg::S_PAYLOAD: begin
				emit = 1'b1; o_byte = b; o_len = skip_q;
				o_first = (rem_q[15:0] == skip_q) && !rem_q[16];
				rem_d = rem_q - 17'sd1;
				o_last = (rem_d <= 17'sd0);
				if (o_last) begin
					st_d = psd_pkg::S_HUNT; win_d = '1;
				end
			end
			default: begin
				st_d = psd_pkg::S_HUNT; win_d = '1;
			end
		endcase
		// shared tails, operating on the updated length
		if (do_m1) begin
			if (b[7:4] == 4'd1) begin
				st_d = psd_pkg::S_HUNT; win_d = '1;
			end else if (b[7:4] == 4'd2 || b[7:4] == 4'd3) begin
				rem_d = rsub(rem_d, (b[7:4] == 4'd2) ? 8'd4 : 8'd9);
				pts_d = psd_pkg::ts_part(4'd0, b); tsf_d = 2'd1;
				hrem_d = (b[7:4] == 4'd3) ? 8'd5 : 8'd0;
				skip_d = 16'd4; st_d = psd_pkg::S_M1_TS;
			end else begin
				rem_d = rsub(rem_d, 8'd1); do_fin = 1'b1;
			end
		end
		if (do_ats) begin
			if (hrem_d != 8'd0) begin
				rem_d = rsub(rem_d, hrem_d);
				skip_d = {8'h00, hrem_d}; st_d = psd_pkg::S_M2_HSKIP;
			end else do_ahdr = 1'b1;
		end
		if (do_ahdr) begin
			if (id_q == psd_pkg::IdPrivate1 && (rem_d > 17'sd5 || rem_d < 17'sd0))
				st_d = psd_pkg::S_P1_SUB;
			else do_fin = 1'b1;
		end
		if (do_fin) begin
			if (rem_d < 17'sd0 || rem_d[15:0] > max_size) begin
				st_d = psd_pkg::S_HUNT; win_d = '1;
			end else if (rem_d == 17'sd0) begin
				emit = 1'b1; o_first = 1'b1; o_last = 1'b1; o_empty = 1'b1;
				st_d = psd_pkg::S_HUNT; win_d = '1;
			end else begin
				skip_d = rem_d[15:0]; st_d = psd_pkg::S_PAYLOAD;
			end
		end
	end

	// fields that reflect the state in force when the result is formed
	assign o_id    = (id_q == psd_pkg::IdPrivate1 || id_q == psd_pkg::IdPrivate2)
		? sub_d : id_q;
	assign o_pts_v = tsf_d[0];
	assign o_dts_v = tsf_d[1];
	assign o_pts   = tsf_d[0] ? pts_d : '0;
	assign o_dts   = tsf_d[1] ? dts_d : '0;
	assign o_off   = start_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= psd_pkg::S_HUNT; win_q <= '1; id_q <= '0; sub_q <= 8'hFF;
			rem_q <= '0; hrem_q <= '0; skip_q <= '0; pts_q <= '0; dts_q <= '0;
			tsf_q <= '0; pos_q <= '0; start_q <= '0;
		end else if (step) begin
			st_q <= st_d; win_q <= win_d; id_q <= id_d; sub_q <= sub_d;
			rem_q <= rem_d; hrem_q <= hrem_d; skip_q <= skip_d; pts_q <= pts_d;
			dts_q <= dts_d; tsf_q <= tsf_d; pos_q <= pos_q + POSITION_BITS'(1);
			start_q <= start_d;
		end
	end

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == psd_pkg::S_PAYLOAD |-> rem_q > 17'sd0 && rem_q <= 17'sd65535)
		else $error("payload entered with bad count");
	a_empty_first: assert property (@(posedge clk) disable iff (!arst_n)
		emit && o_empty |-> o_first && o_last)
		else $error("empty result not a whole packet");
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !o_empty |-> st_q == psd_pkg::S_PAYLOAD)
		else $error("payload byte outside payload phase");
endmodule

// ----- rtl/core/program_stream_pes_demux.sv -----
// An input transfer reaches its result through the input register, the parser
// and the result register. Throughput: one byte per cycle, set by the
// single-pass parser between the two registers, while input is not stalled; a
// held result stalls input only when the result register is full and stalled.
// Reset: arst_n resets all parser state; max_packet_size returns to 65535.
// ----------------------------------------------------------------------------
// program_stream_pes_demux: MPEG program stream PES demultiplexer
// Byte-serial start code hunt, PES header decode and tagged payload output.
// ----------------------------------------------------------------------------
module program_stream_pes_demux #(
	parameter int unsigned POSITION_BITS = psd_pkg::PositionBitsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [15:0]              cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               stream_byte,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               stream_id,
	output logic [7:0]               payload_byte,
	output logic                     first_of_packet,
	output logic                     last_of_packet,
	output logic [15:0]              packet_length,
	output logic [32:0]              pts_value,
	output logic                     pts_valid,
	output logic [32:0]              dts_value,
	output logic                     dts_valid,
	output logic [POSITION_BITS-1:0] packet_offset,
	output logic                     empty_packet
);
	logic [15:0] max_q;
	logic        v_s1;
	logic [7:0]  b_s1;
	logic        step, emit, adv;
	logic [7:0]  p_id, p_byte;
	logic        p_first, p_last, p_pts_v, p_dts_v, p_empty;
	logic [15:0] p_len;
	logic [32:0] p_pts, p_dts;
	logic [POSITION_BITS-1:0] p_off;

	// stage 1 advances when the result register can take whatever it makes
	assign adv      = !out_valid || !out_stall;
	assign step     = v_s1 && adv;
	assign in_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= psd_pkg::MaxPacketSizeReset;
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) max_q <= cfg_wdata;
			if (!in_stall) v_s1 <= in_valid;
			if (adv) out_valid <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) b_s1 <= stream_byte;
		if (step && emit) begin
			stream_id <= p_id; payload_byte <= p_byte; first_of_packet <= p_first;
			last_of_packet <= p_last; packet_length <= p_len; pts_value <= p_pts;
			pts_valid <= p_pts_v; dts_value <= p_dts; dts_valid <= p_dts_v;
			packet_offset <= p_off; empty_packet <= p_empty;
		end
	end

	psd_parser #(.POSITION_BITS(POSITION_BITS)) u_parser (
		.clk, .arst_n, .step, .b(b_s1), .max_size(max_q), .emit,
		.o_id(p_id), .o_byte(p_byte), .o_first(p_first), .o_last(p_last),
		.o_len(p_len), .o_pts(p_pts), .o_pts_v(p_pts_v), .o_dts(p_dts),
		.o_dts_v(p_dts_v), .o_off(p_off), .o_empty(p_empty)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("held result lost");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid && out_stall)
		else $error("input stalled without cause");
	a_step_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step))
		else $error("result without parsed byte");
endmodule
